// File: hw/rtl/tiled_texel_format_packer_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef TILED_TEXEL_FORMAT_PACKER_MACROS_SVH
`define TILED_TEXEL_FORMAT_PACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTFP_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ttfp: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTFP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ttfp: next-cycle check failed");

`endif

// File: hw/rtl/ttfp_pkg.sv
// ----------------------------------------------------------------------------
// ttfp_pkg
// Types and constants shared by the tiled texel format packer.
// ----------------------------------------------------------------------------
package ttfp_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned FmtW      = 3;
  localparam int unsigned GbDepth   = 16;
  localparam int unsigned GbAddrW   = $clog2(GbDepth);
  localparam int unsigned QueueDepth = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgFormat = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgAlpha  = CfgIdxW'(1);

  typedef enum logic [FmtW-1:0] {
    FmtI4     = 3'd0,
    FmtI8     = 3'd1,
    FmtIa4    = 3'd2,
    FmtIa8    = 3'd3,
    FmtRgb565 = 3'd4,
    FmtRgb5a3 = 3'd5,
    FmtRgba8  = 3'd6
  } fmt_e;

  // One classified pixel on its way from the front to the back.
  typedef struct packed {
    logic [WordW-1:0]   word;
    logic               wide;
    logic               last;
    logic               gb_we;
    logic [GbAddrW-1:0] gb_addr;
    logic [WordW-1:0]   gb_word;
    logic               dump;
  } q_entry_t;

endpackage

// File: hw/rtl/ttfp_if.sv
// ----------------------------------------------------------------------------
// ttfp_if
// Valid/ready channels of the texel packer: pixels, results, configuration.
// ----------------------------------------------------------------------------
interface ttfp_pix_if import ttfp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic [ChanW-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface ttfp_res_if import ttfp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] data_word;
  logic             is_wide;
  logic             last_of_run;

  modport source (output valid, data_word, is_wide, last_of_run, input ready);
  modport sink   (input valid, data_word, is_wide, last_of_run, output ready);
endinterface

interface ttfp_cfg_if import ttfp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ttfp_ram.sv
// ----------------------------------------------------------------------------
// ttfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttfp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ttfp_fifo.sv
// ----------------------------------------------------------------------------
// ttfp_fifo
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module ttfp_fifo import ttfp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  q_entry_t        slot_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/ttfp_front.sv
// ----------------------------------------------------------------------------
// ttfp_front
// Accepts pixels, holds the configuration, and turns the pixels into queue
// entries for the selected texel format; I4 packs two pixels per entry.
// ----------------------------------------------------------------------------
module ttfp_front import ttfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ttfp_pix_if.sink  pix_i,
  ttfp_cfg_if.sink  cfg_i,
  input  logic      full_i,
  output logic      push_o,
  output q_entry_t  entry_o
);

  localparam logic [GbAddrW-1:0] LastPos = GbAddrW'(GbDepth - 1);

  logic [FmtW-1:0]    fmt_q;
  logic               has_alpha_q;
  logic [GbAddrW-1:0] pos_q;
  logic [3:0]         nibble_q;

  logic               pix_acc, cfg_acc, cfg_hit;
  logic [9:0]         sum;
  logic [19:0]        prod;
  logic [ChanW-1:0]   inten;
  logic               produce;
  logic [ChanW-1:0]   r, g, b, a;

  assign r = pix_i.red;
  assign g = pix_i.green;
  assign b = pix_i.blue;
  assign a = pix_i.alpha;

  assign pix_i.ready = !full_i;
  assign cfg_i.ready = 1'b1;
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign cfg_hit     = (cfg_i.index == CfgFormat) || (cfg_i.index == CfgAlpha);

  // Divide by three as a multiply by 683/2048; exact for sums up to 765.
  assign sum   = 10'(r) + 10'(g) + 10'(b);
  assign prod  = 20'(sum) * 20'd683;
  assign inten = prod[18:11];

  always_comb begin
    entry_o  = '0;
    produce  = 1'b1;
    entry_o.wide = 1'b1;
    entry_o.last = 1'b1;
    case (fmt_q)
      FmtI4: begin
        entry_o.wide = 1'b0;
        entry_o.word = {8'h00, nibble_q, inten[7:4]};
        produce      = pos_q[0];
      end
      FmtI8: begin
        entry_o.wide = 1'b0;
        entry_o.word = {8'h00, inten};
      end
      FmtIa4: begin
        entry_o.wide = 1'b0;
        entry_o.word = {8'h00, (has_alpha_q ? a[7:4] : 4'hf), inten[7:4]};
      end
      FmtIa8: begin
        entry_o.word = {(has_alpha_q ? a : 8'hff), inten};
      end
      FmtRgb565: begin
        entry_o.word = {r[7:3], g[7:2], b[7:3]};
      end
      FmtRgb5a3: begin
        if (has_alpha_q) begin
          entry_o.word = {1'b0, a[7:5], r[7:4], g[7:4], b[7:4]};
        end else begin
          entry_o.word = {1'b1, r[7:3], g[7:3], b[7:3]};
        end
      end
      FmtRgba8: begin
        entry_o.word    = {a, r};
        entry_o.last    = (pos_q != LastPos);
        entry_o.gb_we   = 1'b1;
        entry_o.gb_addr = pos_q;
        entry_o.gb_word = {g, b};
        entry_o.dump    = (pos_q == LastPos);
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  assign push_o = pix_acc && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FmtI4;
      has_alpha_q <= 1'b0;
      pos_q       <= '0;
      nibble_q    <= '0;
    end else if (cfg_acc) begin
      if (cfg_i.index == CfgFormat) begin
        fmt_q <= cfg_i.data[FmtW-1:0];
      end
      if (cfg_i.index == CfgAlpha) begin
        has_alpha_q <= cfg_i.data[0];
      end
      // Any write to a known register starts a new image.
      if (cfg_hit) begin
        pos_q    <= '0;
        nibble_q <= '0;
      end
    end else if (pix_acc) begin
      pos_q <= pos_q + GbAddrW'(1);
      if (fmt_q == FmtI4 && !pos_q[0]) begin
        nibble_q <= inten[7:4];
      end
    end
  end

endmodule

// File: hw/rtl/ttfp_back.sv
// ----------------------------------------------------------------------------
// ttfp_back
// Drains the queue into the result register, keeps the GB words of an RGBA8
// tile in a small RAM and plays them out after the last pixel of the tile.
// ----------------------------------------------------------------------------
module ttfp_back import ttfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  q_entry_t   head_i,
  output logic       pop_o,
  ttfp_res_if.source res_o
);

  localparam logic [GbAddrW-1:0] LastAddr = GbAddrW'(GbDepth - 1);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StLoad
  } state_e;

  state_e             state_q;
  logic [GbAddrW-1:0] cnt_q;
  logic               out_valid_q;
  logic [WordW-1:0]   out_word_q;
  logic               out_wide_q;
  logic               out_last_q;

  logic               out_free;
  logic [WordW-1:0]   rdata;

  assign out_free = !out_valid_q || res_o.ready;
  assign pop_o    = (state_q == StIdle) && valid_i && out_free;

  ttfp_ram #(
    .Width (WordW),
    .Depth (GbDepth)
  ) u_gb_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && head_i.gb_we),
    .waddr_i (head_i.gb_addr),
    .wdata_i (head_i.gb_word),
    .re_i    (state_q == StRead),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_wide_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (pop_o) begin
            out_valid_q <= 1'b1;
            out_word_q  <= head_i.word;
            out_wide_q  <= head_i.wide;
            out_last_q  <= head_i.last;
            if (head_i.dump) begin
              cnt_q   <= '0;
              state_q <= StRead;
            end
          end
        end
        StRead: begin
          state_q <= StLoad;
        end
        StLoad: begin
          // Read data stays put until the next read, so a stall just waits.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_word_q  <= rdata;
            out_wide_q  <= 1'b1;
            out_last_q  <= (cnt_q == LastAddr);
            cnt_q       <= cnt_q + GbAddrW'(1);
            state_q     <= (cnt_q == LastAddr) ? StIdle : StRead;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.data_word   = out_word_q;
  assign res_o.is_wide     = out_wide_q;
  assign res_o.last_of_run = out_last_q;

endmodule

// File: hw/rtl/tiled_texel_format_packer.sv
// ----------------------------------------------------------------------------
// tiled_texel_format_packer
// Packs RGBA8888 pixels in tile order into I4, I8, IA4, IA8, RGB565, RGB5A3
// or RGBA8 texels.
// ----------------------------------------------------------------------------
// Usage: pixels enter on pix_i, one per request; packed bytes and words leave
// on res_o, each with is_wide and last_of_run. cfg_i writes texel_format
// (index 0) and image_has_alpha (index 1); write only while the block is
// idle. A write to either register restarts the pixel count of the image.
// Path: an accepted pixel is written into the queue, and the result register
// loads it from the queue head when that register is free and no GB play-out runs.
// Throughput: one pixel per cycle while the queue has room, one result per
// cycle out of the result register while the receiver is ready, entries wait
// in the queue and no GB play-out runs. Per pixel: I4 gives one byte every
// second pixel, RGBA8 gives two words, the others one. After the sixteenth
// RGBA8 pixel of a tile the sixteen stored GB words play out of the GB RAM,
// each through a read state (address to the RAM), then a load state.
// Reset: format I4, alpha unused, queue and result register empty.
// Receiver stall: the result register holds its request, the queue fills,
// and pix_i.ready drops when the queue is full.
// ----------------------------------------------------------------------------
module tiled_texel_format_packer import ttfp_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttfp_pix_if.sink   pix_i,
  ttfp_cfg_if.sink   cfg_i,
  ttfp_res_if.source res_o
);

  logic     push, full, pop, q_valid;
  q_entry_t entry, head;

  ttfp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .cfg_i   (cfg_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  ttfp_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  ttfp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// File: hw/rtl/ttfp_checker.sv
// ----------------------------------------------------------------------------
// ttfp_checker
// Port-level checks on the result channel of the texel packer.
// ----------------------------------------------------------------------------
`include "tiled_texel_format_packer_macros.svh"

module ttfp_checker import ttfp_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [WordW-1:0] res_data_i,
  input logic             res_wide_i,
  input logic             res_last_i
);

  // A stalled result stays offered.
  `TTFP_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i)

  // A stalled result keeps its payload.
  `TTFP_ASSERT_NEXT(a_payload_holds, clk_i, rst_ni, res_valid_i && !res_ready_i,
    $stable(res_data_i) && $stable(res_wide_i) && $stable(res_last_i))

  // A byte result sits in the low half of the word.
  `TTFP_ASSERT_IMPLY(a_byte_low, clk_i, rst_ni, res_valid_i && !res_wide_i,
    res_data_i[15:8] == 8'h00)

  // Only RGBA8 results can have last_of_run low, so every byte ends its run.
  `TTFP_ASSERT_IMPLY(a_byte_last, clk_i, rst_ni, res_valid_i && !res_wide_i, res_last_i)

endmodule

bind tiled_texel_format_packer ttfp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data_word),
  .res_wide_i  (res_o.is_wide),
  .res_last_i  (res_o.last_of_run)
);
